@@ rtl/ucbt_pkg.sv @@
// Shared types and constants for the UTF-8 CJK bigram tokenizer.
`default_nettype none

package ucbt_pkg;

   // Most token bytes one text byte can cause: unigram plus bigram of a 3-byte char.
   localparam int unsigned MAX_TOKENS  = 9;
   localparam int unsigned TOK_IDX_W   = $clog2(MAX_TOKENS);
   localparam int unsigned TOK_CNT_W   = $clog2(MAX_TOKENS + 1);
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [7:0] LEAD4_MIN   = 8'hF0;
   localparam logic [7:0] LEAD3_MIN   = 8'hE0;
   localparam logic [7:0] ASCII_LIMIT = 8'd128;

   // One queued burst of token bytes, slot 0 goes out first.
   typedef struct packed {
      logic [TOK_CNT_W-1:0]        count;
      logic [MAX_TOKENS-1:0]       ends;
      logic [MAX_TOKENS-1:0][7:0]  data;
   } cmd_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

endpackage

`default_nettype wire

@@ rtl/utf8_cjk_bigram_tokenizer_unit.sv @@
// Top level of the UTF-8 CJK unigram/bigram tokenizer.
//
// Input stream (req_*): one UTF-8 text byte per transfer, req_tlast on the final
// byte of a text. Output stream (rsp_*): token bytes, ASCII letters lowercased,
// rsp_tuser high on the last byte of each token, rsp_tlast high on the last
// byte caused by one input byte. Input bytes that cause nothing send nothing.
// ASCII token bytes are held back by one input byte so the token end is known.
//
// The token bytes of an input byte are registered as one burst in the command
// queue and go out after any earlier bursts. The front end takes one byte per
// cycle while the command queue (QUEUE_DEPTH bursts) has room; the serializer
// sends one token byte per cycle while the receiver is ready, and an input byte
// causes up to 9 token bytes, so for CJK text the serializer limits the rate.
//
// Reset clears all token and character state and empties the queue. When the
// receiver stalls, the queue fills and req_tready drops; nothing is lost.
`default_nettype none

module utf8_cjk_bigram_tokenizer_unit #(
   parameter int unsigned QUEUE_DEPTH = ucbt_pkg::QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] text_byte
   input  wire logic       req_tlast,   // text_last
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] token_byte
   output logic            rsp_tuser,   // token_end
   output logic            rsp_tlast    // run_last
);

   ucbt_pkg::cmd_type      push_cmd;
   ucbt_pkg::cmd_type      head;
   ucbt_pkg::q_status_type q_status;
   logic                   push;
   logic                   pop;

   ucbt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .cmd        (push_cmd)
   );

   ucbt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   ucbt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ rtl/ucbt_front.sv @@
// Front end: decodes text bytes, tracks token and character state, builds bursts.
`default_nettype none

module ucbt_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] text_byte
   input  wire logic                   req_tlast,   // text_last
   input  wire ucbt_pkg::q_status_type q_status,
   output logic                        push,
   output ucbt_pkg::cmd_type           cmd
);

   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_TWO  = 3'd2;
   localparam logic [2:0] LEN_CJK  = 3'd3;
   localparam logic [2:0] LEN_FOUR = 3'd4;

   logic [7:0]      held_ff, held_in;
   logic            held_vld_ff, held_vld_in;
   logic [1:0]      rem_ff, rem_in;
   logic [2:0]      len_ff, len_in;
   logic [7:0]      cur0_ff, cur0_in;
   logic [7:0]      cur1_ff, cur1_in;
   logic [2:0][7:0] prev_ff, prev_in;
   logic            prev_vld_ff, prev_vld_in;
   logic            accept;
   logic [7:0]      b;
   logic [7:0]      lower_b;

   function automatic logic is_alnum(input logic [7:0] v);
      return (v >= 8'h30 && v <= 8'h39) || (v >= 8'h41 && v <= 8'h5A) ||
             (v >= 8'h61 && v <= 8'h7A);
   endfunction

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign lower_b    = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;

   always_comb begin
      held_in     = held_ff;
      held_vld_in = held_vld_ff;
      rem_in      = rem_ff;
      len_in      = len_ff;
      cur0_in     = cur0_ff;
      cur1_in     = cur1_ff;
      prev_in     = prev_ff;
      prev_vld_in = prev_vld_ff;
      cmd         = '0;

      if (accept) begin
         if (rem_ff != 2'd0) begin
            // inside a multi-byte character, any value continues it
            if (len_ff == LEN_CJK && rem_ff == 2'd2) begin
               cur1_in = b;
            end
            rem_in = rem_ff - 2'd1;
            if (rem_ff == 2'd1) begin
               if (len_ff == LEN_CJK) begin
                  cmd.data[0] = cur0_ff;
                  cmd.data[1] = cur1_ff;
                  cmd.data[2] = b;
                  cmd.ends[2] = 1'b1;
                  cmd.count   = ucbt_pkg::TOK_CNT_W'(3);
                  if (prev_vld_ff) begin
                     cmd.data[3] = prev_ff[0];
                     cmd.data[4] = prev_ff[1];
                     cmd.data[5] = prev_ff[2];
                     cmd.data[6] = cur0_ff;
                     cmd.data[7] = cur1_ff;
                     cmd.data[8] = b;
                     cmd.ends[8] = 1'b1;
                     cmd.count   = ucbt_pkg::TOK_CNT_W'(9);
                  end
                  prev_in     = {b, cur1_ff, cur0_ff};
                  prev_vld_in = 1'b1;
               end else begin
                  prev_vld_in = 1'b0;
               end
               len_in = LEN_NONE;
            end
         end else if (b < ucbt_pkg::ASCII_LIMIT) begin
            prev_vld_in = 1'b0;
            if (is_alnum(b)) begin
               if (held_vld_ff) begin
                  cmd.data[0] = held_ff;
                  cmd.count   = ucbt_pkg::TOK_CNT_W'(1);
                  if (req_tlast) begin
                     cmd.data[1] = lower_b;
                     cmd.ends[1] = 1'b1;
                     cmd.count   = ucbt_pkg::TOK_CNT_W'(2);
                  end
               end else if (req_tlast) begin
                  cmd.data[0] = lower_b;
                  cmd.ends[0] = 1'b1;
                  cmd.count   = ucbt_pkg::TOK_CNT_W'(1);
               end
               held_in     = lower_b;
               held_vld_in = 1'b1;
            end else begin
               if (held_vld_ff) begin
                  cmd.data[0] = held_ff;
                  cmd.ends[0] = 1'b1;
                  cmd.count   = ucbt_pkg::TOK_CNT_W'(1);
               end
               held_vld_in = 1'b0;
            end
         end else begin
            // lead byte (stray continuation bytes count as 2-byte leads)
            if (held_vld_ff) begin
               cmd.data[0] = held_ff;
               cmd.ends[0] = 1'b1;
               cmd.count   = ucbt_pkg::TOK_CNT_W'(1);
            end
            held_vld_in = 1'b0;
            if (b >= ucbt_pkg::LEAD4_MIN) begin
               len_in = LEN_FOUR;
               rem_in = 2'd3;
            end else if (b >= ucbt_pkg::LEAD3_MIN) begin
               len_in  = LEN_CJK;
               rem_in  = 2'd2;
               cur0_in = b;
            end else begin
               len_in = LEN_TWO;
               rem_in = 2'd1;
            end
         end

         if (req_tlast) begin
            held_vld_in = 1'b0;
            rem_in      = 2'd0;
            len_in      = LEN_NONE;
            prev_vld_in = 1'b0;
         end
      end
   end

   assign push = accept && (cmd.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_vld_ff <= 1'b0;
         rem_ff      <= 2'd0;
         len_ff      <= LEN_NONE;
         prev_vld_ff <= 1'b0;
      end else begin
         held_vld_ff <= held_vld_in;
         rem_ff      <= rem_in;
         len_ff      <= len_in;
         prev_vld_ff <= prev_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      cur0_ff <= cur0_in;
      cur1_ff <= cur1_in;
      prev_ff <= prev_in;
   end

endmodule

`default_nettype wire

@@ rtl/ucbt_queue.sv @@
// Short command queue between the front end and the token serializer.
`default_nettype none

module ucbt_queue #(
   parameter int unsigned DEPTH = ucbt_pkg::QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire ucbt_pkg::cmd_type      push_cmd,
   input  wire logic                   pop,
   output ucbt_pkg::cmd_type           head,
   output ucbt_pkg::q_status_type      q_status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   ucbt_pkg::cmd_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_pop;

   assign do_pop = pop && (cnt_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head               = entry_ff[rd_ptr_ff];
   assign q_status.not_empty = (cnt_ff != '0);
   assign q_status.full      = (cnt_ff == CNT_W'(DEPTH));

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != CNT_W'(DEPTH)))
      else $error("queue written while full");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");

endmodule

`default_nettype wire

@@ rtl/ucbt_back.sv @@
// Back end: walks the head burst and sends one token byte per transfer.
`default_nettype none

module ucbt_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ucbt_pkg::cmd_type      head,
   input  wire ucbt_pkg::q_status_type q_status,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [7:0]                  rsp_tdata,   // [7:0] token_byte
   output logic                        rsp_tuser,   // token_end
   output logic                        rsp_tlast    // run_last
);

   logic [ucbt_pkg::TOK_IDX_W-1:0] idx_ff, idx_in;
   logic                           xfer;
   logic                           burst_done;

   assign rsp_tvalid = q_status.not_empty;
   assign rsp_tdata  = head.data[idx_ff];
   assign rsp_tuser  = head.ends[idx_ff];
   assign burst_done = (ucbt_pkg::TOK_CNT_W'(idx_ff) + 1'b1) == head.count;
   assign rsp_tlast  = burst_done;
   assign xfer       = rsp_tvalid && rsp_tready;
   assign pop        = xfer && burst_done;

   always_comb begin
      idx_in = idx_ff;
      if (xfer) begin
         idx_in = burst_done ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   a_idx_in_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (ucbt_pkg::TOK_CNT_W'(idx_ff) < head.count))
      else $error("token index past end of burst");

   a_no_empty_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (head.count != '0))
      else $error("empty burst in queue");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (xfer && !burst_done) |=> (rsp_tvalid && idx_ff != '0))
      else $error("burst lost before its last byte");

endmodule

`default_nettype wire
